/* rtl/kwsc_pkg.sv */
// ----------------------------------------------------------------------------
// kwsc_pkg
// shared types, command codes and letter helpers for the keyword cipher
// ----------------------------------------------------------------------------
`default_nettype none

package kwsc_pkg;

	localparam int ALPHABET_SIZE = 26;
	localparam int IDX_W         = 5;

	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ALPHABET_SIZE - 1);
	localparam logic [IDX_W-1:0] FULL_FILL = IDX_W'(ALPHABET_SIZE);

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;

	// command codes
	localparam logic [2:0] CMD_START   = 3'd0;
	localparam logic [2:0] CMD_KEY     = 3'd1;
	localparam logic [2:0] CMD_END     = 3'd2;
	localparam logic [2:0] CMD_ENCRYPT = 3'd3;
	localparam logic [2:0] CMD_DECRYPT = 3'd4;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] in_char;
	} req_beat_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       status;
	} rsp_beat_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [IDX_W-1:0] data;
	} tbl_wr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} tbl_rd_t;

	typedef struct packed {
		logic busy;
		logic ready;
	} key_status_t;

	typedef struct packed {
		logic             is_letter;
		logic             upper;
		logic [IDX_W-1:0] idx;
	} letter_t;

	typedef enum logic [3:0] {
		SEQ_IDLE = 4'b0001,
		SEQ_FILL = 4'b0010,
		SEQ_INV  = 4'b0100,
		SEQ_DONE = 4'b1000
	} seq_state_t;

	// classify a byte as letter, its case and alphabet position
	function automatic letter_t decode_letter(input logic [7:0] ch);
		letter_t    l;
		logic [7:0] diff;
		l.upper     = (ch >= CHAR_UPPER_A) && (ch <= CHAR_UPPER_Z);
		l.is_letter = l.upper || ((ch >= CHAR_LOWER_A) && (ch <= CHAR_LOWER_Z));
		diff        = ch - (l.upper ? CHAR_UPPER_A : CHAR_LOWER_A);
		l.idx       = diff[IDX_W-1:0];
		return l;
	endfunction

	// alphabet position back to a byte of the given case
	function automatic logic [7:0] letter_char(input logic [IDX_W-1:0] idx,
		input logic upper);
		return (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + {3'b000, idx};
	endfunction

endpackage

`default_nettype wire

/* rtl/keyword_substitution_cipher_top.sv */
// a taken request beat moves through stage 1 into the output register before its result beat is offered
// throughput: one beat per cycle for start, key letter, encrypt and decrypt while the response side is not stalled
// an end-key beat holds off further requests while the sequencer runs its fill
// steps, the forward-table reads feeding the inverse writes, and a finishing step
// reset clears the used-letter map, fill index, ready flag and the pipeline;
// the tables hold nothing valid until the first end-key build completes
// ----------------------------------------------------------------------------
// keyword_substitution_cipher_top
// keyword monoalphabetic substitution cipher with table memories
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_substitution_cipher_top (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_ready,
	input  kwsc_pkg::req_beat_t  req,
	output logic                 rsp_valid,
	input  wire                  rsp_ready,
	output kwsc_pkg::rsp_beat_t  rsp
);

	// request side decode
	logic                         req_accept;
	kwsc_pkg::letter_t            req_letter;
	logic                         is_crypt;
	logic                         do_map;

	// keyword control and tables
	kwsc_pkg::key_status_t        key_status;
	kwsc_pkg::tbl_wr_t            fwd_wr;
	kwsc_pkg::tbl_rd_t            seq_fwd_rd;
	kwsc_pkg::tbl_rd_t            fwd_rd;
	kwsc_pkg::tbl_wr_t            inv_wr;
	kwsc_pkg::tbl_rd_t            inv_rd;
	logic [kwsc_pkg::IDX_W-1:0]   fwd_rd_data;
	logic [kwsc_pkg::IDX_W-1:0]   inv_rd_data;

	// stage 1: waiting for table read data
	logic                         valid_s1;
	logic                         map_s1;
	logic                         inv_s1;
	logic                         upper_s1;
	kwsc_pkg::rsp_beat_t          pass_s1;
	logic                         advance_s1;
	logic                         out_free;

	// output register
	logic                         rsp_valid_q;
	kwsc_pkg::rsp_beat_t          rsp_q;
	logic [kwsc_pkg::IDX_W-1:0]   map_idx;

	assign out_free   = !rsp_valid_q || rsp_ready;
	assign advance_s1 = valid_s1 && out_free;
	assign req_ready  = !key_status.busy && (!valid_s1 || advance_s1);
	assign req_accept = req_valid && req_ready;

	assign req_letter = kwsc_pkg::decode_letter(req.in_char);
	assign is_crypt   = (req.cmd == kwsc_pkg::CMD_ENCRYPT)
		|| (req.cmd == kwsc_pkg::CMD_DECRYPT);
	// only a letter with a ready alphabet needs a table lookup
	assign do_map     = is_crypt && key_status.ready && req_letter.is_letter;

	// the sequencer owns the forward read port while it runs
	always_comb begin
		if (key_status.busy) begin
			fwd_rd = seq_fwd_rd;
		end else begin
			fwd_rd.en   = req_accept && do_map && (req.cmd == kwsc_pkg::CMD_ENCRYPT);
			fwd_rd.addr = req_letter.idx;
		end
	end

	assign inv_rd.en   = req_accept && do_map && (req.cmd == kwsc_pkg::CMD_DECRYPT);
	assign inv_rd.addr = req_letter.idx;

	kwsc_key_ctrl u_key_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_accept  (req_accept),
		.cmd         (req.cmd),
		.key_letter  (req_letter.is_letter),
		.key_idx     (req_letter.idx),
		.fwd_rd_data (fwd_rd_data),
		.key_status  (key_status),
		.fwd_wr      (fwd_wr),
		.fwd_rd      (seq_fwd_rd),
		.inv_wr      (inv_wr)
	);

	kwsc_tables u_tables (
		.clk         (clk),
		.fwd_wr      (fwd_wr),
		.fwd_rd      (fwd_rd),
		.fwd_rd_data (fwd_rd_data),
		.inv_wr      (inv_wr),
		.inv_rd      (inv_rd),
		.inv_rd_data (inv_rd_data)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload: either a finished result or a pending lookup
	always_ff @(posedge clk) begin
		if (req_accept) begin
			map_s1   <= do_map;
			inv_s1   <= (req.cmd == kwsc_pkg::CMD_DECRYPT);
			upper_s1 <= req_letter.upper;
			if (is_crypt) begin
				// not ready echoes with status set, non-letters pass through
				pass_s1.out_char <= req.in_char;
				pass_s1.status   <= !key_status.ready;
			end else begin
				pass_s1 <= '0;
			end
		end
	end

	// read data holds until the next lookup, which cannot start before advance
	assign map_idx = inv_s1 ? inv_rd_data : fwd_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			if (map_s1) begin
				rsp_q.out_char <= kwsc_pkg::letter_char(map_idx, upper_s1);
				rsp_q.status   <= 1'b0;
			end else begin
				rsp_q <= pass_s1;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// requests are blocked for the whole key build
	a_block_busy: assert property (@(posedge clk) disable iff (!arst_n)
		key_status.busy |-> !req_ready)
		else $error("request taken during key build");

	// a lookup is only pending with a ready alphabet
	a_map_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && map_s1) |-> key_status.ready)
		else $error("lookup pending without ready alphabet");

	// a held stage 1 beat is never overwritten
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance_s1) |-> !req_accept)
		else $error("stage 1 overwritten while stalled");

endmodule

`default_nettype wire

/* rtl/kwsc_tables.sv */
// ----------------------------------------------------------------------------
// kwsc_tables
// forward and inverse substitution memories, registered reads
// ----------------------------------------------------------------------------
`default_nettype none

module kwsc_tables (
	input  wire                           clk,
	input  kwsc_pkg::tbl_wr_t             fwd_wr,
	input  kwsc_pkg::tbl_rd_t             fwd_rd,
	output logic [kwsc_pkg::IDX_W-1:0]    fwd_rd_data,
	input  kwsc_pkg::tbl_wr_t             inv_wr,
	input  kwsc_pkg::tbl_rd_t             inv_rd,
	output logic [kwsc_pkg::IDX_W-1:0]    inv_rd_data
);

	logic [kwsc_pkg::IDX_W-1:0] fwd_mem [kwsc_pkg::ALPHABET_SIZE];
	logic [kwsc_pkg::IDX_W-1:0] inv_mem [kwsc_pkg::ALPHABET_SIZE];

	// forward table: plain position to cipher letter
	always_ff @(posedge clk) begin
		if (fwd_wr.en && (fwd_wr.addr <= kwsc_pkg::LAST_IDX)) begin
			fwd_mem[fwd_wr.addr] <= fwd_wr.data;
		end
		if (fwd_rd.en && (fwd_rd.addr <= kwsc_pkg::LAST_IDX)) begin
			fwd_rd_data <= fwd_mem[fwd_rd.addr];
		end
	end

	// inverse table: cipher letter to plain position
	always_ff @(posedge clk) begin
		if (inv_wr.en && (inv_wr.addr <= kwsc_pkg::LAST_IDX)) begin
			inv_mem[inv_wr.addr] <= inv_wr.data;
		end
		if (inv_rd.en && (inv_rd.addr <= kwsc_pkg::LAST_IDX)) begin
			inv_rd_data <= inv_mem[inv_rd.addr];
		end
	end

endmodule

`default_nettype wire

/* rtl/kwsc_key_ctrl.sv */
// ----------------------------------------------------------------------------
// kwsc_key_ctrl
// keyword state and the end-of-key fill and inverse build sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module kwsc_key_ctrl (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cmd_accept,
	input  wire  [2:0]                    cmd,
	input  wire                           key_letter,
	input  wire  [kwsc_pkg::IDX_W-1:0]    key_idx,
	input  wire  [kwsc_pkg::IDX_W-1:0]    fwd_rd_data,
	output kwsc_pkg::key_status_t         key_status,
	output kwsc_pkg::tbl_wr_t             fwd_wr,
	output kwsc_pkg::tbl_rd_t             fwd_rd,
	output kwsc_pkg::tbl_wr_t             inv_wr
);

	kwsc_pkg::seq_state_t                     state_q;
	logic [kwsc_pkg::ALPHABET_SIZE-1:0]       used_q;
	logic [kwsc_pkg::IDX_W-1:0]               fill_q;
	logic [kwsc_pkg::IDX_W-1:0]               k_q;
	logic                                     ready_q;
	logic                                     rd_pend_s1;
	logic [kwsc_pkg::IDX_W-1:0]               k_s1;
	logic                                     key_append;

	assign key_append = cmd_accept && (cmd == kwsc_pkg::CMD_KEY) && key_letter
		&& (fill_q < kwsc_pkg::FULL_FILL) && !used_q[key_idx];

	always_comb begin
		fwd_wr = '0;
		if (key_append) begin
			fwd_wr.en   = 1'b1;
			fwd_wr.addr = fill_q;
			fwd_wr.data = key_idx;
		end else if (state_q == kwsc_pkg::SEQ_FILL) begin
			fwd_wr.en   = !used_q[k_q];
			fwd_wr.addr = fill_q;
			fwd_wr.data = k_q;
		end
	end

	assign fwd_rd.en   = (state_q == kwsc_pkg::SEQ_INV);
	assign fwd_rd.addr = k_q;

	assign inv_wr.en   = rd_pend_s1;
	assign inv_wr.addr = fwd_rd_data;
	assign inv_wr.data = k_s1;

	assign key_status.busy  = (state_q != kwsc_pkg::SEQ_IDLE);
	assign key_status.ready = ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= kwsc_pkg::SEQ_IDLE;
			used_q     <= '0;
			fill_q     <= '0;
			k_q        <= '0;
			ready_q    <= 1'b0;
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= 1'b0;
			unique case (state_q)
				kwsc_pkg::SEQ_IDLE: begin
					if (cmd_accept && (cmd == kwsc_pkg::CMD_START)) begin
						used_q  <= '0;
						fill_q  <= '0;
						ready_q <= 1'b0;
					end else if (key_append) begin
						used_q[key_idx] <= 1'b1;
						fill_q          <= kwsc_pkg::IDX_W'(fill_q + 1'b1);
					end else if (cmd_accept && (cmd == kwsc_pkg::CMD_END)) begin
						state_q <= kwsc_pkg::SEQ_FILL;
						k_q     <= '0;
					end
				end
				// check one letter per cycle and append it if the keyword left it out
				kwsc_pkg::SEQ_FILL: begin
					if (!used_q[k_q]) begin
						used_q[k_q] <= 1'b1;
						fill_q      <= kwsc_pkg::IDX_W'(fill_q + 1'b1);
					end
					if (k_q == kwsc_pkg::LAST_IDX) begin
						state_q <= kwsc_pkg::SEQ_INV;
						k_q     <= '0;
					end else begin
						k_q <= kwsc_pkg::IDX_W'(k_q + 1'b1);
					end
				end
				// read forward entry, write inverse entry in the cycle after
				kwsc_pkg::SEQ_INV: begin
					rd_pend_s1 <= 1'b1;
					if (k_q == kwsc_pkg::LAST_IDX) begin
						state_q <= kwsc_pkg::SEQ_DONE;
					end else begin
						k_q <= kwsc_pkg::IDX_W'(k_q + 1'b1);
					end
				end
				kwsc_pkg::SEQ_DONE: begin
					ready_q <= 1'b1;
					state_q <= kwsc_pkg::SEQ_IDLE;
				end
				default: begin
					state_q <= kwsc_pkg::SEQ_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == kwsc_pkg::SEQ_INV) begin
			k_s1 <= k_q;
		end
	end

	// fill position always equals the number of letters placed
	a_fill_matches_used: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == 32'(fill_q))
		else $error("fill index out of step with used-letter map");

	// a ready alphabet is always complete
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> (fill_q == kwsc_pkg::FULL_FILL))
		else $error("alphabet ready with incomplete fill");

	// no command taken while the sequencer runs
	a_no_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != kwsc_pkg::SEQ_IDLE) |-> !cmd_accept)
		else $error("command accepted during key build");

	// the fill pass always ends with a full alphabet
	a_fill_done_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kwsc_pkg::SEQ_INV) |-> (fill_q == kwsc_pkg::FULL_FILL))
		else $error("inverse build started on incomplete alphabet");

endmodule

`default_nettype wire

/* tb/sv/tb_keyword_substitution_cipher_top.sv */
// ----------------------------------------------------------------------------
// tb_keyword_substitution_cipher_top
// self-checking bench for the keyword substitution cipher: request beats are
// mirrored into a behavioural cipher model, and every response beat is
// compared with the oldest predicted beat under random stalls on both sides
// ----------------------------------------------------------------------------
`default_nettype none

module tb_keyword_substitution_cipher_top;

	timeunit 1ns;
	timeprecision 1ps;

	import kwsc_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 5;
	localparam int RANDOM_ITEMS  = 950;
	localparam int NO_IDLE_ITEMS = 250;
	localparam int IDLE_PCT      = 25;
	localparam int HOLD_CYCLES   = 300;
	localparam int TAIL_CYCLES   = 20;
	localparam int CYCLE_LIMIT   = 500000;

	// codes the block has no meaning for
	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	req_beat_t req;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_beat_t rsp;

	keyword_substitution_cipher_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// ------------------------------------------------------------------------
	// clock and run limit
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	int cycle_count = 0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// behavioural cipher state, kept in step with accepted request beats
	// ------------------------------------------------------------------------
	logic [IDX_W-1:0]         plain_to_cipher [ALPHABET_SIZE];
	logic [IDX_W-1:0]         cipher_to_plain [ALPHABET_SIZE];
	logic [ALPHABET_SIZE-1:0] letters_taken = '0;
	int                       next_slot     = 0;
	logic                     alphabet_built = 1'b0;

	rsp_beat_t expected_beats[$];
	int        mismatches = 0;

	// append a letter to the cipher alphabet unless already placed or full
	function automatic void place_letter(input logic [IDX_W-1:0] pos);
		if (next_slot >= ALPHABET_SIZE || letters_taken[pos])
			return;
		plain_to_cipher[next_slot] = pos;
		letters_taken[pos]         = 1'b1;
		next_slot++;
	endfunction

	// advance the cipher state by one request beat and return its response
	function automatic rsp_beat_t cipher_predict(input req_beat_t b);
		rsp_beat_t        r;
		logic             is_upper;
		logic             is_lower;
		logic [IDX_W-1:0] pos;
		logic [IDX_W-1:0] mapped;
		r        = '0;
		is_upper = (b.in_char >= CHAR_UPPER_A) && (b.in_char <= CHAR_UPPER_Z);
		is_lower = (b.in_char >= CHAR_LOWER_A) && (b.in_char <= CHAR_LOWER_Z);
		pos      = is_upper ? IDX_W'(b.in_char - CHAR_UPPER_A)
		                    : IDX_W'(b.in_char - CHAR_LOWER_A);
		case (b.cmd)
			CMD_START: begin
				letters_taken  = '0;
				next_slot      = 0;
				alphabet_built = 1'b0;
			end
			CMD_KEY: begin
				if (is_upper || is_lower)
					place_letter(pos);
			end
			CMD_END: begin
				for (int k = 0; k < ALPHABET_SIZE; k++)
					place_letter(IDX_W'(k));
				for (int k = 0; k < ALPHABET_SIZE; k++)
					cipher_to_plain[plain_to_cipher[k]] = IDX_W'(k);
				alphabet_built = 1'b1;
			end
			CMD_ENCRYPT, CMD_DECRYPT: begin
				if (!alphabet_built) begin
					r.out_char = b.in_char;
					r.status   = 1'b1;
				end else if (!(is_upper || is_lower)) begin
					r.out_char = b.in_char;
				end else begin
					mapped     = (b.cmd == CMD_ENCRYPT) ? plain_to_cipher[pos]
					                                    : cipher_to_plain[pos];
					r.out_char = (is_upper ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'(mapped);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// beat checker: predict on request beats, compare on response beats
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : beat_checker
		rsp_beat_t want;
		if (arst_n && req_valid && req_ready)
			expected_beats.push_back(cipher_predict(req));
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_beats.size() == 0) begin
				$display("%0t: response beat with nothing expected, got char %h status %b",
					$time, rsp.out_char, rsp.status);
				mismatches++;
			end else begin
				want = expected_beats.pop_front();
				if (rsp.out_char !== want.out_char) begin
					$display("%0t: out_char expected %h, got %h",
						$time, want.out_char, rsp.out_char);
					mismatches++;
				end
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %b, got %b",
						$time, want.status, rsp.status);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// receiver: random ready, plus a long hold-off on request
	// ------------------------------------------------------------------------
	int   tx_idle_pct = IDLE_PCT;
	int   rx_idle_pct = IDLE_PCT;
	logic rx_holding  = 1'b0;
	event rx_hold_go;

	// hold-off length is counted here, on rising edges, read on falling ones
	always begin : rx_hold_timer
		@(rx_hold_go);
		@(posedge clk);
		rx_holding = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_holding = 1'b0;
	end

	always @(negedge clk) begin
		if (rx_holding)
			rsp_ready <= 1'b0;
		else
			rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// ------------------------------------------------------------------------
	// sender helpers
	// ------------------------------------------------------------------------

	// offer one request beat and wait until it is taken
	task automatic send_beat(input logic [2:0] cmd, input logic [7:0] ch);
		int gap;
		@(negedge clk);
		gap = 0;
		if ($urandom_range(99) < tx_idle_pct)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid   <= 1'b1;
		req.cmd     <= cmd;
		req.in_char <= ch;
		do @(posedge clk); while (!req_ready);
	endtask

	// pause the sender until every predicted beat has come back
	task automatic wait_for_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] random_letter();
		return ($urandom_range(1) ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'($urandom_range(25));
	endfunction

	// mostly letters, now and then any byte at all
	function automatic logic [7:0] random_text_byte();
		if ($urandom_range(99) < 75)
			return random_letter();
		return 8'($urandom_range(255));
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// nothing built yet: echo with not-ready status, spare codes give zero
	task automatic test_before_ready();
		send_beat(CMD_ENCRYPT, "a");
		send_beat(CMD_DECRYPT, 8'hff);
		send_beat(CMD_ENCRYPT, 8'h00);
		send_beat(CMD_SPARE_LAST, 8'hff);
		send_beat(CMD_SPARE_FIRST, 8'h00);
		wait_for_results();
	endtask

	// end with no start gives the identity, and a second end keeps it
	task automatic test_identity_alphabet();
		send_beat(CMD_END, 8'h00);
		send_beat(CMD_ENCRYPT, "M");
		send_beat(CMD_DECRYPT, "q");
		send_beat(CMD_END, 8'hff);
		send_beat(CMD_ENCRYPT, "Z");
		wait_for_results();
	endtask

	// case folding, repeated letters, non-letters, and keys after the fill
	task automatic test_keyword_rules();
		send_beat(CMD_START, 8'h00);
		send_beat(CMD_KEY, "z");
		send_beat(CMD_KEY, "Z");
		send_beat(CMD_KEY, "1");
		send_beat(CMD_KEY, 8'hff);
		send_beat(CMD_KEY, "A");
		send_beat(CMD_END, 8'h00);
		send_beat(CMD_KEY, "Q");
		send_beat(CMD_ENCRYPT, "a");
		send_beat(CMD_DECRYPT, "Z");
		send_beat(CMD_ENCRYPT, 8'h80);
		wait_for_results();
	endtask

	// start while ready drops the alphabet; an empty keyword rebuilds identity
	task automatic test_restart();
		send_beat(CMD_START, 8'hff);
		send_beat(CMD_ENCRYPT, "b");
		send_beat(CMD_END, 8'h00);
		send_beat(CMD_DECRYPT, "B");
		wait_for_results();
	endtask

	// receiver stalls for a long stretch while the sender keeps offering
	task automatic test_backpressure();
		tx_idle_pct = 0;
		-> rx_hold_go;
		send_beat(CMD_START, 8'h00);
		for (int k = 0; k < ALPHABET_SIZE; k++)
			send_beat(CMD_KEY, random_letter());
		send_beat(CMD_END, 8'h00);
		for (int k = 0; k < 40; k++)
			send_beat($urandom_range(1) ? CMD_ENCRYPT : CMD_DECRYPT, random_text_byte());
		wait_for_results();
		tx_idle_pct = IDLE_PCT;
	endtask

	// mostly complete key sessions with random text, some broken ones, some noise
	task automatic test_random_traffic();
		int       counted;
		int       pick;
		int       n;
		logic [2:0] cmd;
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			// an opening stretch with no idling on either side
			if (counted < NO_IDLE_ITEMS) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else begin
				tx_idle_pct = IDLE_PCT;
				rx_idle_pct = IDLE_PCT;
			end
			pick = $urandom_range(99);
			if (pick < 80) begin
				send_beat(CMD_START, 8'($urandom_range(255)));
				n = $urandom_range(0, 30);
				for (int k = 0; k < n; k++) begin
					if ($urandom_range(9) == 0)
						send_beat(CMD_KEY, 8'($urandom_range(255)));
					else
						send_beat(CMD_KEY, random_letter());
				end
				send_beat(CMD_END, 8'($urandom_range(255)));
				counted += n + 2;
				n = $urandom_range(1, 40);
				for (int k = 0; k < n; k++)
					send_beat($urandom_range(1) ? CMD_ENCRYPT : CMD_DECRYPT,
						random_text_byte());
				counted += n;
			end else if (pick < 90) begin
				// keyword left open: text must come back echoed, not ready
				send_beat(CMD_START, 8'($urandom_range(255)));
				n = $urandom_range(0, 8);
				for (int k = 0; k < n; k++)
					send_beat(CMD_KEY, random_letter());
				send_beat($urandom_range(1) ? CMD_ENCRYPT : CMD_DECRYPT, random_text_byte());
				counted += n + 2;
			end else begin
				n = $urandom_range(1, 10);
				for (int k = 0; k < n; k++) begin
					cmd = 3'($urandom_range(7));
					send_beat(cmd, 8'($urandom_range(255)));
					if (cmd <= CMD_DECRYPT)
						counted++;
				end
			end
			// occasional full pause of the sender
			if ($urandom_range(19) == 0)
				wait_for_results();
		end
		wait_for_results();
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		test_before_ready();
		test_identity_alphabet();
		test_keyword_rules();
		test_restart();
		test_backpressure();
		test_random_traffic();

		// let any stray beat show up before the verdict
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_beats.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
